>>> src/wwm_pkg.sv
// Package for the wildcard word match unit.
// Holds shared constants, the configuration and result structs and the pattern lookup.
// No dependencies.
`default_nettype none

package wwm_pkg;

  // Default sizing for the top level parameters.
  localparam int MAX_PATTERN_DEFAULT = 32;
  localparam int COUNT_BITS_DEFAULT  = 24;

  // Fixed field widths.
  localparam int CHAR_BITS      = 8;
  localparam int LEN_BITS       = 6;
  localparam int STAR_BITS      = 5;
  localparam int OUT_COUNT_BITS = 24;
  localparam int PAT_CHARS      = 32;
  localparam int PAT_BITS       = PAT_CHARS * CHAR_BITS;

  // Configuration bus sizing: seven 64-bit registers at 8-byte spacing.
  localparam int DATA_BITS = 64;
  localparam int ADDR_BITS = 6;
  localparam int REG_BITS  = ADDR_BITS - 3;

  // Register indexes, taken from the address in 8-byte steps.
  localparam logic [REG_BITS-1:0] REG_PAT_A  = 3'd0;
  localparam logic [REG_BITS-1:0] REG_PAT_B  = 3'd1;
  localparam logic [REG_BITS-1:0] REG_PAT_C  = 3'd2;
  localparam logic [REG_BITS-1:0] REG_PAT_D  = 3'd3;
  localparam logic [REG_BITS-1:0] REG_LENGTH = 3'd4;
  localparam logic [REG_BITS-1:0] REG_MODE   = 3'd5;
  localparam logic [REG_BITS-1:0] REG_STAR   = 3'd6;

  // The wildcard character of fixed mode.
  localparam logic [CHAR_BITS-1:0] CHAR_QUESTION = 8'h3F;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [PAT_BITS-1:0]  pattern_bytes;
    logic [LEN_BITS-1:0]  pattern_length;
    logic                 match_mode;
    logic [STAR_BITS-1:0] star_position;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic                      matched;
    logic [OUT_COUNT_BITS-1:0] word_number;
    logic [OUT_COUNT_BITS-1:0] match_count;
  } result_t;

  // Pattern character at a position; positions past the stored pattern read as zero.
  function automatic logic [CHAR_BITS-1:0] pat_char(input logic [PAT_BITS-1:0] pat,
                                                     input logic [LEN_BITS-1:0] idx);
    logic [CHAR_BITS-1:0] ch;
    ch = pat[{idx[STAR_BITS-1:0], 3'b000} +: CHAR_BITS];
    if (idx[LEN_BITS-1]) begin
      ch = '0;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> src/wwm_cfg.sv
// Configuration register file of the wildcard word match unit.
// APB-style write and read access to the pattern, length, mode and star position.
// Depends on wwm_pkg.
`default_nettype none

module wwm_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [wwm_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [wwm_pkg::DATA_BITS-1:0] pwdata,
  output logic      [wwm_pkg::DATA_BITS-1:0] prdata,
  output logic                               pready,
  output wwm_pkg::cfg_t                      cfg
);

  logic [wwm_pkg::REG_BITS-1:0] reg_index;
  logic                         write_en;

  assign reg_index = paddr[wwm_pkg::ADDR_BITS-1:3];
  assign write_en  = psel & penable & pwrite & pready;
  assign pready    = 1'b1;

  // Register writes; addresses beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_bytes  <= '0;
      cfg.pattern_length <= wwm_pkg::LEN_BITS'(1);
      cfg.match_mode     <= 1'b0;
      cfg.star_position  <= '0;
    end else if (write_en) begin
      case (reg_index)
        wwm_pkg::REG_PAT_A:  cfg.pattern_bytes[0*64 +: 64] <= pwdata;
        wwm_pkg::REG_PAT_B:  cfg.pattern_bytes[1*64 +: 64] <= pwdata;
        wwm_pkg::REG_PAT_C:  cfg.pattern_bytes[2*64 +: 64] <= pwdata;
        wwm_pkg::REG_PAT_D:  cfg.pattern_bytes[3*64 +: 64] <= pwdata;
        wwm_pkg::REG_LENGTH: cfg.pattern_length <= pwdata[wwm_pkg::LEN_BITS-1:0];
        wwm_pkg::REG_MODE:   cfg.match_mode     <= pwdata[0];
        wwm_pkg::REG_STAR:   cfg.star_position  <= pwdata[wwm_pkg::STAR_BITS-1:0];
        default:             ;
      endcase
    end
  end

  // Read data, zero extended.
  always_comb begin
    case (reg_index)
      wwm_pkg::REG_PAT_A:  prdata = cfg.pattern_bytes[0*64 +: 64];
      wwm_pkg::REG_PAT_B:  prdata = cfg.pattern_bytes[1*64 +: 64];
      wwm_pkg::REG_PAT_C:  prdata = cfg.pattern_bytes[2*64 +: 64];
      wwm_pkg::REG_PAT_D:  prdata = cfg.pattern_bytes[3*64 +: 64];
      wwm_pkg::REG_LENGTH: prdata = wwm_pkg::DATA_BITS'(cfg.pattern_length);
      wwm_pkg::REG_MODE:   prdata = wwm_pkg::DATA_BITS'(cfg.match_mode);
      wwm_pkg::REG_STAR:   prdata = wwm_pkg::DATA_BITS'(cfg.star_position);
      default:             prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> src/wwm_cell.sv
// One cell of the suffix window chain.
// Holds one character, takes its neighbor's character on each transfer and checks it.
// Depends on wwm_pkg.
`default_nettype none

module wwm_cell (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          shift,
  input  wire logic [wwm_pkg::CHAR_BITS-1:0] char_in,
  input  wire logic [wwm_pkg::CHAR_BITS-1:0] expect_char,
  input  wire logic                          check_en,
  output logic      [wwm_pkg::CHAR_BITS-1:0] char_out,
  output logic                               ok
);

  // The character this cell will hold after the shift is the one checked.
  assign ok = ~check_en | (char_in == expect_char);

  // Window storage; the chain moves one place on every accepted character.
  always_ff @(posedge clk) begin
    if (rst) begin
      char_out <= '0;
    end else if (shift) begin
      char_out <= char_in;
    end
  end

endmodule

`default_nettype wire

>>> src/wildcard_word_match_unit.sv
// Wildcard word match unit: matches streamed words against a configured pattern.
// Depends on wwm_pkg, wwm_cfg and wwm_cell.
//
// Usage: words arrive one character per transfer on the input channel
// (word_char, end_of_word with in_valid/in_ready). The transfer that carries
// end_of_word produces one result on the output channel (matched, word_number,
// match_count with out_valid/out_ready); other characters produce none.
// The pattern, its length, the mode and the star position are written through
// the APB-style port while no word is in flight.
// Throughput is one character per cycle while in_ready is high: every
// character is compared on arrival, the fixed and prefix checks against
// the pattern character at its position, and the suffix checks in a chain
// of MAX_PATTERN window cells that shifts once per transfer. The result is
// registered in the output register, or in the skid register behind it.
// The output side has a main register and a skid register, so input keeps
// flowing while one result waits; in_ready drops only when both are full.
// Reset clears the configuration to its defaults (pattern length one, fixed
// mode), empties the output stage, zeroes the window and both counters.
`default_nettype none

module wildcard_word_match_unit #(
  parameter int MAX_PATTERN = wwm_pkg::MAX_PATTERN_DEFAULT,
  parameter int COUNT_BITS  = wwm_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [wwm_pkg::CHAR_BITS-1:0]      word_char,
  input  wire logic                               end_of_word,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    matched,
  output logic      [wwm_pkg::OUT_COUNT_BITS-1:0] word_number,
  output logic      [wwm_pkg::OUT_COUNT_BITS-1:0] match_count,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [wwm_pkg::ADDR_BITS-1:0]      paddr,
  input  wire logic [wwm_pkg::DATA_BITS-1:0]      pwdata,
  output logic      [wwm_pkg::DATA_BITS-1:0]      prdata,
  output logic                                    pready
);

  localparam int LB = wwm_pkg::LEN_BITS;
  localparam int CB = wwm_pkg::CHAR_BITS;
  localparam int OB = wwm_pkg::OUT_COUNT_BITS;

  wwm_pkg::cfg_t cfg;

  // Word tracking state.
  logic [LB-1:0]         char_position;
  logic                  fixed_ok;
  logic                  prefix_ok;
  logic [COUNT_BITS-1:0] word_counter;
  logic [COUNT_BITS-1:0] match_counter;

  // Output stage.
  wwm_pkg::result_t out_data;
  wwm_pkg::result_t skid_data;
  logic             skid_valid;

  logic accept;
  logic push;
  logic pop;

  wwm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_ready = ~skid_valid;
  assign accept   = in_valid & in_ready;
  assign push     = accept & end_of_word;
  assign pop      = out_valid & out_ready;

  // Effective length, prefix and suffix lengths, all held in seven bits.
  logic [LB:0] eff_len;
  logic [LB:0] pre_len;
  logic [LB:0] suf_len;
  logic        star_in;

  always_comb begin
    if ({1'b0, cfg.pattern_length} > (LB+1)'(MAX_PATTERN)) begin
      eff_len = (LB+1)'(MAX_PATTERN);
    end else begin
      eff_len = {1'b0, cfg.pattern_length};
    end
    star_in = (LB+1)'(cfg.star_position) < eff_len;
    if (star_in) begin
      pre_len = (LB+1)'(cfg.star_position);
      suf_len = eff_len - (LB+1)'(cfg.star_position) - (LB+1)'(1);
    end else begin
      pre_len = eff_len;
      suf_len = '0;
    end
  end

  // Per-character checks against the pattern character at this position.
  logic [CB-1:0] pos_char;
  logic [LB:0]   pos_plus1;
  logic          fixed_ok_next;
  logic          prefix_ok_next;

  always_comb begin
    pos_char  = wwm_pkg::pat_char(cfg.pattern_bytes, char_position);
    pos_plus1 = {1'b0, char_position} + (LB+1)'(1);
    fixed_ok_next = fixed_ok;
    if ({1'b0, char_position} >= eff_len) begin
      fixed_ok_next = 1'b0;
    end else if (pos_char != wwm_pkg::CHAR_QUESTION && pos_char != word_char) begin
      fixed_ok_next = 1'b0;
    end
    prefix_ok_next = prefix_ok;
    if ({1'b0, char_position} < pre_len && pos_char != word_char) begin
      prefix_ok_next = 1'b0;
    end
  end

  // Suffix window: cell j holds the j-th newest character and checks it
  // against pattern character eff_len-1-j while j is inside the suffix.
  logic [CB-1:0]          win_char [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_ok;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic [LB:0]   pat_idx;
    logic [CB-1:0] expect_char;
    logic          check_en;
    logic [CB-1:0] char_in;

    assign pat_idx     = eff_len - (LB+1)'(j) - (LB+1)'(1);
    assign expect_char = wwm_pkg::pat_char(cfg.pattern_bytes, pat_idx[LB-1:0]);
    assign check_en    = (LB+1)'(j) < suf_len;

    if (j == 0) begin : g_head
      assign char_in = word_char;
    end else begin : g_link
      assign char_in = win_char[j-1];
    end

    wwm_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .shift       (accept),
      .char_in     (char_in),
      .expect_char (expect_char),
      .check_en    (check_en),
      .char_out    (win_char[j]),
      .ok          (cell_ok[j])
    );
  end

  // Word verdict on the last character.
  logic                  hit;
  logic [COUNT_BITS-1:0] match_counter_next;

  always_comb begin
    if (cfg.match_mode) begin
      hit = prefix_ok_next & (pos_plus1 >= pre_len + suf_len) & (&cell_ok);
    end else begin
      hit = fixed_ok_next & (pos_plus1 == eff_len);
    end
    match_counter_next = match_counter;
    if (hit && match_counter != {COUNT_BITS{1'b1}}) begin
      match_counter_next = match_counter + COUNT_BITS'(1);
    end
  end

  // Result item, counters resized to the output width.
  wwm_pkg::result_t new_result;
  logic [COUNT_BITS+OB-1:0] word_wide;
  logic [COUNT_BITS+OB-1:0] match_wide;

  always_comb begin
    word_wide              = (COUNT_BITS+OB)'(word_counter);
    match_wide             = (COUNT_BITS+OB)'(match_counter_next);
    new_result.matched     = hit;
    new_result.word_number = word_wide[OB-1:0];
    new_result.match_count = match_wide[OB-1:0];
  end

  // Word tracking registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      char_position <= '0;
      fixed_ok      <= 1'b1;
      prefix_ok     <= 1'b1;
      word_counter  <= '0;
      match_counter <= '0;
    end else if (accept) begin
      if (end_of_word) begin
        char_position <= '0;
        fixed_ok      <= 1'b1;
        prefix_ok     <= 1'b1;
        word_counter  <= word_counter + COUNT_BITS'(1);
        match_counter <= match_counter_next;
      end else begin
        fixed_ok  <= fixed_ok_next;
        prefix_ok <= prefix_ok_next;
        if (char_position != {LB{1'b1}}) begin
          char_position <= pos_plus1[LB-1:0];
        end
      end
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data  <= new_result;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= new_result;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign matched     = out_data.matched;
  assign word_number = out_data.word_number;
  assign match_count = out_data.match_count;

  // The skid register only fills behind a held output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  // A character that does not end a word leaves the word counter alone.
  a_word_count_hold: assert property (@(posedge clk) disable iff (rst)
    (!rst && accept && !end_of_word) |=> $stable(word_counter))
    else $error("word counter moved inside a word");

  // The end of a word restarts the per-word tracking.
  a_word_restart: assert property (@(posedge clk) disable iff (rst)
    (!rst && push) |=> (char_position == '0 && fixed_ok && prefix_ok))
    else $error("word tracking not restarted after end of word");

  // Inside a word the position steps by one until it saturates.
  a_position_step: assert property (@(posedge clk) disable iff (rst)
    (!rst && accept && !end_of_word && char_position != {LB{1'b1}})
      |=> (char_position == $past(char_position) + LB'(1)))
    else $error("character position did not advance");

  // The match counter never moves backward.
  a_match_count_mono: assert property (@(posedge clk) disable iff (rst)
    !rst |=> (match_counter >= $past(match_counter)))
    else $error("match counter decreased");

endmodule

`default_nettype wire

>>> verif/tb_wildcard_word_match_unit.sv
// Testbench for wildcard_word_match_unit: streams words through the character channel
// and checks every word result against a cycle-free model of the matcher.
// Depends on wwm_pkg and the unit itself.
`default_nettype none

typedef logic [wwm_pkg::CHAR_BITS-1:0] char_q_t[$];

// Tracks configuration and word state, predicts each word verdict and checks results.
class word_match_scoreboard;
  bit [63:0]                        pat_word [4];
  bit [wwm_pkg::LEN_BITS-1:0]       pat_len = 6'd1;
  bit                               star_mode;
  bit [wwm_pkg::STAR_BITS-1:0]      star_pos;
  bit [wwm_pkg::LEN_BITS-1:0]       char_pos;
  bit                               fixed_ok = 1'b1;
  bit                               prefix_ok = 1'b1;
  bit [wwm_pkg::CHAR_BITS-1:0]      window [wwm_pkg::PAT_CHARS];
  bit [wwm_pkg::OUT_COUNT_BITS-1:0] word_cnt;
  bit [wwm_pkg::OUT_COUNT_BITS-1:0] match_cnt;
  wwm_pkg::result_t                 pending_verdicts[$];
  int unsigned                      mismatches;

  function void set_reg(logic [wwm_pkg::REG_BITS-1:0] idx, logic [63:0] value);
    case (idx)
      wwm_pkg::REG_PAT_A:  pat_word[0] = value;
      wwm_pkg::REG_PAT_B:  pat_word[1] = value;
      wwm_pkg::REG_PAT_C:  pat_word[2] = value;
      wwm_pkg::REG_PAT_D:  pat_word[3] = value;
      wwm_pkg::REG_LENGTH: pat_len = value[wwm_pkg::LEN_BITS-1:0];
      wwm_pkg::REG_MODE:   star_mode = value[0];
      wwm_pkg::REG_STAR:   star_pos = value[wwm_pkg::STAR_BITS-1:0];
      default: ;
    endcase
  endfunction

  function bit [wwm_pkg::CHAR_BITS-1:0] pat_at(int unsigned i);
    if (i >= wwm_pkg::PAT_CHARS) begin
      return '0;
    end
    return pat_word[i >> 3][(i & 7) * 8 +: 8];
  endfunction

  // Pattern length clipped to the stored pattern size.
  function int unsigned eff_len();
    return (pat_len > wwm_pkg::PAT_CHARS) ? wwm_pkg::PAT_CHARS : pat_len;
  endfunction

  // Characters that must match before the star.
  function int unsigned prefix_len();
    return (star_pos < eff_len()) ? star_pos : eff_len();
  endfunction

  function int unsigned pending();
    return pending_verdicts.size();
  endfunction

  function void report(string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s", msg);
    end
  endfunction

  // Update the word state with one accepted character; a last character queues a verdict.
  function void note_char(logic [wwm_pkg::CHAR_BITS-1:0] ch, logic last);
    int unsigned idx, len, pre, suf, k;
    bit hit;
    bit [wwm_pkg::CHAR_BITS-1:0] pc;
    idx = char_pos;
    len = eff_len();
    pre = prefix_len();
    suf = (star_pos < len) ? len - star_pos - 1 : 0;

    // Fixed mode: position must lie in the pattern, '?' accepts anything.
    if (idx >= len) begin
      fixed_ok = 1'b0;
    end else begin
      pc = pat_at(idx);
      if (pc != wwm_pkg::CHAR_QUESTION && pc != ch) begin
        fixed_ok = 1'b0;
      end
    end
    // Star mode: literal prefix comparison.
    if (idx < pre && pat_at(idx) != ch) begin
      prefix_ok = 1'b0;
    end

    // Newest character enters the window at entry zero.
    for (k = wwm_pkg::PAT_CHARS - 1; k > 0; k--) begin
      window[k] = window[k-1];
    end
    window[0] = ch;

    if (!last) begin
      if (char_pos != 6'd63) begin
        char_pos++;
      end
      return;
    end

    if (star_mode) begin
      hit = prefix_ok && (idx + 1 >= pre + suf);
      for (k = 0; k < suf; k++) begin
        if (window[suf-1-k] != pat_at(star_pos + 1 + k)) begin
          hit = 1'b0;
        end
      end
    end else begin
      hit = fixed_ok && (idx + 1 == len);
    end

    if (hit && match_cnt != '1) begin
      match_cnt++;
    end
    pending_verdicts.push_back('{matched: hit, word_number: word_cnt, match_count: match_cnt});
    word_cnt++;
    char_pos = '0;
    fixed_ok = 1'b1;
    prefix_ok = 1'b1;
  endfunction

  // Compare one result transfer with the oldest waiting verdict.
  function void check_result(logic m, logic [wwm_pkg::OUT_COUNT_BITS-1:0] wn,
                             logic [wwm_pkg::OUT_COUNT_BITS-1:0] mc);
    wwm_pkg::result_t want;
    if (pending_verdicts.size() == 0) begin
      report($sformatf("unexpected result: matched=%0b number=%0d count=%0d", m, wn, mc));
      return;
    end
    want = pending_verdicts.pop_front();
    if (m !== want.matched || wn !== want.word_number || mc !== want.match_count) begin
      report($sformatf("word %0d: expected matched=%0b number=%0d count=%0d, got %0b %0d %0d",
                       want.word_number, want.matched, want.word_number, want.match_count,
                       m, wn, mc));
    end
  endfunction
endclass

module tb_wildcard_word_match_unit;

  localparam int ADDR_W       = wwm_pkg::ADDR_BITS;
  localparam int RANDOM_ITEMS = 1650;
  localparam int PHASE_ITEMS  = 60;
  localparam int HOLD_CYCLES  = 120;
  localparam int SETTLE       = 4;
  localparam int CYCLE_LIMIT  = 400000;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [wwm_pkg::CHAR_BITS-1:0]      word_char = '0;
  logic                               end_of_word = 1'b0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic                               matched;
  logic [wwm_pkg::OUT_COUNT_BITS-1:0] word_number;
  logic [wwm_pkg::OUT_COUNT_BITS-1:0] match_count;
  logic                               psel = 1'b0;
  logic                               penable = 1'b0;
  logic                               pwrite = 1'b0;
  logic [ADDR_W-1:0]                  paddr = '0;
  logic [wwm_pkg::DATA_BITS-1:0]      pwdata = '0;
  logic [wwm_pkg::DATA_BITS-1:0]      prdata;
  logic                               pready;

  word_match_scoreboard sb = new();
  bit          steady;
  bit          hold_output;
  int unsigned chars_sent;
  int unsigned cycle_count;

  wildcard_word_match_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .word_char   (word_char),
    .end_of_word (end_of_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .matched     (matched),
    .word_number (word_number),
    .match_count (match_count),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Observe both channels at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        sb.check_result(matched, word_number, match_count);
      end
      if (in_valid && in_ready) begin
        sb.note_char(word_char, end_of_word);
      end
    end
  end

  // Result receiver: random stalls, or one long hold-off when requested.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_output = 1'b0;
        out_ready <= 1'b1;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 16);
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // One configuration write: setup cycle, then access cycle until pready.
  // psel stays high between the writes of one batch.
  task automatic write_reg(input logic [wwm_pkg::REG_BITS-1:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic configure(input logic [63:0] pa, input logic [63:0] pb, input logic [63:0] pc,
                           input logic [63:0] pd, input int unsigned len, input bit mode,
                           input int unsigned star);
    write_reg(wwm_pkg::REG_PAT_A, pa);
    write_reg(wwm_pkg::REG_PAT_B, pb);
    write_reg(wwm_pkg::REG_PAT_C, pc);
    write_reg(wwm_pkg::REG_PAT_D, pd);
    write_reg(wwm_pkg::REG_LENGTH, 64'(len));
    write_reg(wwm_pkg::REG_MODE, 64'(mode));
    write_reg(wwm_pkg::REG_STAR, 64'(star));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one character and hold it until the transfer completes.
  task automatic send_char(input logic [wwm_pkg::CHAR_BITS-1:0] ch, input logic last);
    if (!steady && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    word_char   <= ch;
    end_of_word <= last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic send_word(input char_q_t w);
    foreach (w[i]) begin
      send_char(w[i], i == w.size() - 1);
    end
  endtask

  task automatic send_text(input string s);
    char_q_t w;
    for (int i = 0; i < s.len(); i++) begin
      w.push_back(s[i]);
    end
    send_word(w);
  endtask

  // Stop offering and wait until every verdict has been delivered.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic [63:0] pattern_word(int unsigned style);
    logic [63:0] v;
    case (style)
      0: v = '1;
      1: v = '0;
      2: v = {$urandom, $urandom};
      default: begin
        // Small alphabet so that noise words still hit the pattern now and then.
        for (int b = 0; b < 8; b++) begin
          v[b*8 +: 8] = ($urandom_range(3) == 0) ? wwm_pkg::CHAR_QUESTION :
                        8'(8'h61 + $urandom_range(2));
        end
      end
    endcase
    return v;
  endfunction

  // A word built to satisfy the current pattern; the middle only applies in star mode.
  function automatic char_q_t make_candidate(int unsigned middle);
    char_q_t w;
    int unsigned len;
    logic [wwm_pkg::CHAR_BITS-1:0] pc;
    len = sb.eff_len();
    if (!sb.star_mode) begin
      for (int unsigned i = 0; i < len; i++) begin
        pc = sb.pat_at(i);
        w.push_back((pc == wwm_pkg::CHAR_QUESTION) ? 8'($urandom) : pc);
      end
    end else begin
      for (int unsigned i = 0; i < sb.prefix_len(); i++) begin
        w.push_back(sb.pat_at(i));
      end
      repeat (middle) w.push_back(8'($urandom));
      for (int unsigned i = sb.star_pos + 1; i < len; i++) begin
        w.push_back(sb.pat_at(i));
      end
    end
    if (w.size() == 0) begin
      w.push_back(8'($urandom));
    end
    return w;
  endfunction

  // Mostly well-formed words, some damaged ones, some noise and a few very long ones.
  function automatic char_q_t pick_word();
    char_q_t w;
    int unsigned r, i;
    r = $urandom_range(99);
    if (r < 3) begin
      w = make_candidate($urandom_range(60, 75));
      while (w.size() < 70) w.push_back(8'($urandom));
    end else if (r < 18) begin
      repeat ($urandom_range(1, 12)) w.push_back(8'($urandom));
    end else begin
      w = make_candidate($urandom_range(0, 4));
      if (r >= 78) begin
        i = $urandom_range(w.size() - 1);
        case ($urandom_range(2))
          0: w[i] = w[i] ^ 8'(1 << $urandom_range(7));
          1: if (w.size() > 1) w.pop_back();
          default: w.insert(i, 8'($urandom));
        endcase
      end
    end
    return w;
  endfunction

  // Random setting for one phase; the first phases pin the extremes.
  task automatic random_config(input int unsigned phase);
    int unsigned len, star, r, eff;
    bit mode;
    case (phase)
      0: configure('1, '1, '1, '1, 32, 1'b0, 0);
      1: configure('0, '0, '0, '0, 63, 1'b1, 31);
      2: configure(pattern_word(2), pattern_word(2), pattern_word(2), pattern_word(2),
                   32, 1'b1, 0);
      default: begin
        r = $urandom_range(15);
        len = (r == 0) ? 0 : (r == 1) ? 32 : (r == 2) ? $urandom_range(33, 63) :
              (r == 3) ? 1 : $urandom_range(2, 10);
        eff = (len > wwm_pkg::PAT_CHARS) ? wwm_pkg::PAT_CHARS : len;
        r = $urandom_range(7);
        star = (r == 0) ? 0 : (r == 1) ? 31 : (r == 2) ? $urandom_range(31) :
               (eff > 0) ? $urandom_range(eff - 1) : 0;
        mode = $urandom_range(1);
        configure(pattern_word($urandom_range(5)), pattern_word($urandom_range(5)),
                  pattern_word($urandom_range(5)), pattern_word($urandom_range(5)),
                  len, mode, star);
      end
    endcase
  endtask

  initial begin
    int unsigned random_start, phase_start, phase;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset pattern is one zero byte: exact hit, wrong byte, and a word too long.
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    send_char(8'h00, 1'b0);
    send_char(8'h00, 1'b1);
    wait_idle();

    // Star mode "a?*a": the question mark is literal, and a short word fails on length.
    configure(64'h612A3F61, '0, '0, '0, 4, 1'b1, 2);
    send_text("a?a");
    send_text("aba");
    send_text("a");
    wait_idle();

    // Zero pattern length never matches in fixed mode.
    configure(64'h61, '0, '0, '0, 0, 1'b0, 0);
    send_text("a");
    wait_idle();

    // Star past the end of the pattern leaves a pure prefix check.
    configure(64'h3F61, '0, '0, '0, 2, 1'b1, 31);
    send_text("a?xx");
    wait_idle();

    // Random phases, each under a fresh setting written while the unit is idle.
    random_start = chars_sent;
    phase = 0;
    while (chars_sent - random_start < RANDOM_ITEMS) begin
      random_config(phase);
      steady = (phase >= 6 && phase <= 8);
      if (phase == 4) begin
        hold_output = 1'b1;
      end
      phase_start = chars_sent;
      while (chars_sent - phase_start < PHASE_ITEMS) begin
        send_word(pick_word());
      end
      wait_idle();
      phase++;
    end

    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
